// File: hw/rtl/rsrs_pkg.sv
// ----------------------------------------------------------------------------
// rsrs_pkg
// Shared types and constants of the run-length sprite run scaler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rsrs_pkg;

  // Configuration register indexes.
  localparam logic [1:0] CFG_ORIGIN_X  = 2'd0;
  localparam logic [1:0] CFG_ORIGIN_Y  = 2'd1;
  localparam logic [1:0] CFG_DRAW_SIZE = 2'd2;

  localparam int unsigned CfgDataW    = 11;
  localparam int unsigned DrawSizeW   = 10;
  localparam logic [9:0]  DRAW_SIZE_RST = 10'd64;

  // Saturation limits of the result fields.
  localparam int          RectPosMin = -1024;
  localparam int          RectPosMax = 2047;
  localparam int unsigned RectWMax   = 8191;
  localparam int unsigned RectHMax   = 1023;

  typedef struct packed {
    logic [7:0] run_length;
    logic [7:0] color_code;
    logic       frame_start;
  } in_t;

  typedef struct packed {
    logic signed [11:0] rect_x;
    logic signed [11:0] rect_y;
    logic        [12:0] rect_w;
    logic        [9:0]  rect_h;
    logic        [7:0]  fill_index;
  } out_t;

  typedef struct packed {
    logic signed [10:0] origin_x;
    logic signed [10:0] origin_y;
    logic        [9:0]  draw_size;
  } cfg_t;

  // One run after the position stage.
  typedef struct packed {
    logic       valid;
    logic [7:0] count;
    logic [7:0] color;
  } run_t;

endpackage

`default_nettype wire

// File: hw/rtl/rsrs_pos.sv
// ----------------------------------------------------------------------------
// rsrs_pos
// Pixel position accumulator and first pipeline stage of the run scaler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rsrs_pos #(
  parameter int unsigned FRAME_W = 64,
  parameter int unsigned FRAME_H = 64,
  localparam int unsigned Total  = FRAME_W * FRAME_H,
  localparam int unsigned PW     = $clog2(Total + 1)
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            en_i,
  input  wire logic            in_valid_i,
  input  wire rsrs_pkg::in_t   in_data_i,
  output      logic [PW-1:0]   pos_o,
  output      rsrs_pkg::run_t  run_o
);

  // The sum must hold a position inside the frame plus the longest run, even
  // for the smallest frames where the position is narrower than a run length.
  localparam int unsigned SW = ((PW > 8) ? PW : 8) + 1;

  logic [PW-1:0] pos_q, pos_d;
  logic [PW-1:0] base;
  logic [SW-1:0] sum;
  logic          in_frame;
  logic          accept;
  logic          s1_valid_q;
  logic [PW-1:0] s1_pos_q;
  logic [7:0]    s1_count_q;
  logic [7:0]    s1_color_q;

  assign accept = in_valid_i && en_i;

  always_comb begin
    base     = in_data_i.frame_start ? '0 : pos_q;
    in_frame = base < PW'(Total);
    sum      = SW'(base) + SW'(in_data_i.run_length);
    pos_d    = pos_q;
    if (accept) begin
      if (!in_frame) begin
        pos_d = base;
      end else if (sum > SW'(Total)) begin
        pos_d = PW'(Total);
      end else begin
        pos_d = sum[PW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      pos_q <= pos_d;
      if (en_i) begin
        s1_valid_q <= accept && in_frame && (in_data_i.color_code != 8'd0);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_pos_q   <= base;
      s1_count_q <= in_data_i.run_length;
      s1_color_q <= in_data_i.color_code;
    end
  end

  assign pos_o = s1_pos_q;
  assign run_o = '{valid: s1_valid_q, count: s1_count_q, color: s1_color_q};

  // The position never runs past the end of the frame.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= PW'(Total))
    else $error("pixel position beyond frame end");

  // A frame start restarts the position from zero before the run is added.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_data_i.frame_start |=>
      ((SW'($past(in_data_i.run_length)) > SW'(Total)) ?
        (pos_q == PW'(Total)) :
        (SW'(pos_q) == SW'($past(in_data_i.run_length)))))
    else $error("position not restarted on frame start");

endmodule

`default_nettype wire

// File: hw/rtl/rsrs_cdiv.sv
// ----------------------------------------------------------------------------
// rsrs_cdiv
// Exact division by a constant through a registered reciprocal product.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rsrs_cdiv #(
  parameter int unsigned DIVISOR = 64,
  parameter int unsigned IN_W    = 16,
  localparam int unsigned LD     = $clog2(DIVISOR),
  localparam int unsigned QW     = IN_W - LD + 1
) (
  input  wire logic            clk_i,
  input  wire logic            en_i,
  input  wire logic [IN_W-1:0] value_i,
  output      logic [QW-1:0]   quot_o
);

  // With a shift of IN_W plus ceil(log2) of the divisor, the rounded-up
  // reciprocal gives the exact floor quotient for every IN_W-bit value.
  localparam int unsigned     SH  = IN_W + LD;
  localparam int unsigned     MW  = IN_W + 1;
  localparam int unsigned     PRW = IN_W + MW;
  localparam longint unsigned Mul = ((64'd1 << SH) + DIVISOR - 1) / DIVISOR;
  localparam logic [MW-1:0]   MulK = MW'(Mul);

  logic [PRW-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= PRW'(value_i) * PRW'(MulK);
    end
  end

  assign quot_o = prod_q[SH +: QW];

endmodule

`default_nettype wire

// File: hw/rtl/rsrs_geom.sv
// ----------------------------------------------------------------------------
// rsrs_geom
// Row and column split, scaling and saturation of one run into a rectangle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rsrs_geom #(
  parameter int unsigned FRAME_W = 64,
  parameter int unsigned FRAME_H = 64,
  localparam int unsigned Total  = FRAME_W * FRAME_H,
  localparam int unsigned PW     = $clog2(Total + 1)
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            en_i,
  input  wire rsrs_pkg::cfg_t  cfg_i,
  input  wire logic [PW-1:0]   pos_i,
  input  wire rsrs_pkg::run_t  run_i,
  output      logic            out_valid_o,
  output      rsrs_pkg::out_t  out_data_o
);

  localparam int unsigned DW  = rsrs_pkg::DrawSizeW;
  localparam int unsigned CW  = $clog2(FRAME_W);
  localparam int unsigned RW  = $clog2(FRAME_H + 1);
  localparam int unsigned CCW = $clog2(FRAME_W + 256);
  localparam int unsigned LIN = CW + DW;
  localparam int unsigned RIN = CCW + DW;
  localparam int unsigned TIN = RW + DW;
  localparam int unsigned PQ  = PW - $clog2(FRAME_W) + 1;
  localparam int unsigned LQ  = LIN - $clog2(FRAME_W) + 1;
  localparam int unsigned RQ  = RIN - $clog2(FRAME_W) + 1;
  localparam int unsigned TQ  = TIN - $clog2(FRAME_H) + 1;
  localparam int unsigned XW  = 14;

  // Stage 2: row quotient product.
  logic            s2_valid_q;
  logic [PW-1:0]   s2_pos_q;
  logic [7:0]      s2_count_q, s2_color_q;
  logic [PQ-1:0]   row_quot;

  // Stage 3: row and column.
  logic            s3_valid_q;
  logic [RW-1:0]   s3_row_q;
  logic [CW-1:0]   s3_col_q;
  logic [7:0]      s3_count_q, s3_color_q;
  logic [PW-1:0]   row_base;
  logic [PW-1:0]   col_full;

  // Stage 4: edges times draw size.
  logic            s4_valid_q;
  logic [RW-1:0]   s4_row_q;
  logic [CW-1:0]   s4_col_q;
  logic [7:0]      s4_count_q, s4_color_q;
  logic [LIN-1:0]  s4_lprod_q;
  logic [RIN-1:0]  s4_rprod_q;
  logic [TIN-1:0]  s4_tprod_q, s4_bprod_q;
  logic [CCW-1:0]  col_end;

  // Stage 5: scaled edges.
  logic            s5_valid_q;
  logic [RW-1:0]   s5_row_q;
  logic [CW-1:0]   s5_col_q;
  logic [7:0]      s5_count_q, s5_color_q;
  logic [LQ-1:0]   left_q;
  logic [RQ-1:0]   right_q;
  logic [TQ-1:0]   top_q, bottom_q;

  // Stage 6: result register.
  logic            out_valid_q;
  rsrs_pkg::out_t  out_q, out_d;
  logic            native;
  logic signed [XW-1:0] rx_s, ry_s, rx_c, ry_c;
  logic [31:0]     rw_ext, rh_ext;
  logic [RQ-1:0]   rw_span;
  logic [TQ-1:0]   rh_span;

  rsrs_cdiv #(.DIVISOR(FRAME_W), .IN_W(PW)) u_row_div (
    .clk_i   (clk_i),
    .en_i    (en_i),
    .value_i (pos_i),
    .quot_o  (row_quot)
  );

  assign row_base = PW'(row_quot) * PW'(FRAME_W);
  assign col_full = s2_pos_q - row_base;
  assign col_end  = CCW'(s3_col_q) + CCW'(s3_count_q);

  rsrs_cdiv #(.DIVISOR(FRAME_W), .IN_W(LIN)) u_left_div (
    .clk_i   (clk_i),
    .en_i    (en_i),
    .value_i (s4_lprod_q),
    .quot_o  (left_q)
  );

  rsrs_cdiv #(.DIVISOR(FRAME_W), .IN_W(RIN)) u_right_div (
    .clk_i   (clk_i),
    .en_i    (en_i),
    .value_i (s4_rprod_q),
    .quot_o  (right_q)
  );

  rsrs_cdiv #(.DIVISOR(FRAME_H), .IN_W(TIN)) u_top_div (
    .clk_i   (clk_i),
    .en_i    (en_i),
    .value_i (s4_tprod_q),
    .quot_o  (top_q)
  );

  rsrs_cdiv #(.DIVISOR(FRAME_H), .IN_W(TIN)) u_bottom_div (
    .clk_i   (clk_i),
    .en_i    (en_i),
    .value_i (s4_bprod_q),
    .quot_o  (bottom_q)
  );

  always_comb begin
    native  = cfg_i.draw_size == DW'(FRAME_W);
    rw_span = right_q - RQ'(left_q);
    rh_span = bottom_q - top_q;
    rw_ext  = 32'(rw_span);
    rh_ext  = 32'(rh_span);
    if (native) begin
      rx_s   = XW'(cfg_i.origin_x) + XW'(s5_col_q);
      ry_s   = XW'(cfg_i.origin_y) + XW'(s5_row_q);
      rw_ext = 32'(s5_count_q);
      rh_ext = 32'd1;
    end else begin
      rx_s = XW'(cfg_i.origin_x) + XW'(left_q);
      ry_s = XW'(cfg_i.origin_y) + XW'(top_q);
      if (rw_ext == 32'd0) begin
        rw_ext = 32'd1;
      end
      if (rh_ext == 32'd0) begin
        rh_ext = 32'd1;
      end
    end

    if (rx_s < XW'(rsrs_pkg::RectPosMin)) begin
      rx_c = XW'(rsrs_pkg::RectPosMin);
    end else if (rx_s > XW'(rsrs_pkg::RectPosMax)) begin
      rx_c = XW'(rsrs_pkg::RectPosMax);
    end else begin
      rx_c = rx_s;
    end
    if (ry_s < XW'(rsrs_pkg::RectPosMin)) begin
      ry_c = XW'(rsrs_pkg::RectPosMin);
    end else if (ry_s > XW'(rsrs_pkg::RectPosMax)) begin
      ry_c = XW'(rsrs_pkg::RectPosMax);
    end else begin
      ry_c = ry_s;
    end

    out_d.rect_x     = 12'(rx_c);
    out_d.rect_y     = 12'(ry_c);
    out_d.rect_w     = (rw_ext > 32'(rsrs_pkg::RectWMax)) ? 13'(rsrs_pkg::RectWMax)
                                                          : 13'(rw_ext);
    out_d.rect_h     = (rh_ext > 32'(rsrs_pkg::RectHMax)) ? 10'(rsrs_pkg::RectHMax)
                                                          : 10'(rh_ext);
    out_d.fill_index = s5_color_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      s4_valid_q  <= 1'b0;
      s5_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en_i) begin
      s2_valid_q  <= run_i.valid;
      s3_valid_q  <= s2_valid_q;
      s4_valid_q  <= s3_valid_q;
      s5_valid_q  <= s4_valid_q;
      out_valid_q <= s5_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s2_pos_q   <= pos_i;
      s2_count_q <= run_i.count;
      s2_color_q <= run_i.color;

      s3_row_q   <= RW'(row_quot);
      s3_col_q   <= col_full[CW-1:0];
      s3_count_q <= s2_count_q;
      s3_color_q <= s2_color_q;

      s4_row_q   <= s3_row_q;
      s4_col_q   <= s3_col_q;
      s4_count_q <= s3_count_q;
      s4_color_q <= s3_color_q;
      s4_lprod_q <= LIN'(s3_col_q) * LIN'(cfg_i.draw_size);
      s4_rprod_q <= RIN'(col_end) * RIN'(cfg_i.draw_size);
      s4_tprod_q <= TIN'(s3_row_q) * TIN'(cfg_i.draw_size);
      s4_bprod_q <= TIN'(s3_row_q + RW'(1)) * TIN'(cfg_i.draw_size);

      s5_row_q   <= s4_row_q;
      s5_col_q   <= s4_col_q;
      s5_count_q <= s4_count_q;
      s5_color_q <= s4_color_q;

      out_q      <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// File: hw/rtl/rle_sprite_run_scaler.sv
// ----------------------------------------------------------------------------
// rle_sprite_run_scaler
// Turns run-length sprite pairs into filled screen rectangles.
// ----------------------------------------------------------------------------
// Usage: the input channel carries one run per transfer (run length, palette
// index, frame-start flag). The output channel carries one rectangle per
// non-transparent run that starts inside the FRAME_W x FRAME_H sprite;
// transparent runs and runs past the frame end produce no transfer.
// Both channels use valid and stall; a transfer completes on a rising edge
// with valid high and stall low. The configuration port writes origin_x,
// origin_y and draw_size with a single-cycle write enable. The user must
// write it only while the pipeline is empty; the block does not enforce it.
// The pipeline takes one run per cycle while the output is not stalled;
// the only loop between runs is the position accumulator, whose next
// position is formed combinationally from the accepted run. The row and scaled
// edge divisions are reciprocal multiplies, each followed by a register.
// Reset clears the pixel position, empties the pipeline and loads the
// registers with origin 0,0 and draw size 64. While the output is valid and
// stalled, the whole pipeline holds and the input stall is raised.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rle_sprite_run_scaler #(
  parameter int unsigned FRAME_W = 64,
  parameter int unsigned FRAME_H = 64
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [1:0]                        cfg_idx_i,
  input  wire logic [rsrs_pkg::CfgDataW-1:0]     cfg_wdata_i,
  input  wire logic                              in_valid_i,
  output      logic                              in_stall_o,
  input  wire rsrs_pkg::in_t                     in_data_i,
  output      logic                              out_valid_o,
  input  wire logic                              out_stall_i,
  output      rsrs_pkg::out_t                    out_data_o
);

  localparam int unsigned Total = FRAME_W * FRAME_H;
  localparam int unsigned PW    = $clog2(Total + 1);

  rsrs_pkg::cfg_t cfg_q;
  logic           pipe_en;
  logic [PW-1:0]  run_pos;
  rsrs_pkg::run_t run_info;

  // The pipeline moves as one whenever the result register is free or its
  // rectangle is being taken in this cycle. Empty slots travel as bubbles.
  assign pipe_en    = !out_valid_o || !out_stall_i;
  assign in_stall_o = !pipe_en;

  // Configuration registers. Writes to the unused index are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.origin_x  <= '0;
      cfg_q.origin_y  <= '0;
      cfg_q.draw_size <= rsrs_pkg::DRAW_SIZE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        rsrs_pkg::CFG_ORIGIN_X: begin
          cfg_q.origin_x <= cfg_wdata_i;
        end
        rsrs_pkg::CFG_ORIGIN_Y: begin
          cfg_q.origin_y <= cfg_wdata_i;
        end
        rsrs_pkg::CFG_DRAW_SIZE: begin
          cfg_q.draw_size <= cfg_wdata_i[rsrs_pkg::DrawSizeW-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Position accumulator: stamps each run with its starting pixel and
  // decides whether it yields a rectangle at all.
  rsrs_pos #(.FRAME_W(FRAME_W), .FRAME_H(FRAME_H)) u_pos (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (pipe_en),
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .pos_o      (run_pos),
    .run_o      (run_info)
  );

  // Row/column split, scaling to the draw size and saturation.
  rsrs_geom #(.FRAME_W(FRAME_W), .FRAME_H(FRAME_H)) u_geom (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (pipe_en),
    .cfg_i       (cfg_q),
    .pos_i       (run_pos),
    .run_i       (run_info),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

  // Only non-transparent runs may reach the output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.fill_index != 8'd0)
    else $error("transparent run produced a rectangle");

  // Every rectangle is at least one pixel high.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.rect_h != 10'd0)
    else $error("rectangle with zero height");

endmodule

`default_nettype wire

// File: tb/tb_rle_sprite_run_scaler.sv
// ----------------------------------------------------------------------------
// tb_rle_sprite_run_scaler
// Self-checking testbench for the run-length sprite run scaler.
// ----------------------------------------------------------------------------
// Runs are sent one transfer at a time. An in-bench predictor keeps its own
// copy of the sprite position and the registers. It queues the rectangle
// each accepted run should produce. A checker pops that queue for every
// output transfer and compares it field by field.
// A short directed part covers:
//   - field extremes and native strips,
//   - the scaled path with extreme and zero draw sizes,
//   - the frame-end hold.
// Random frames then run under several register settings. Both sides insert
// random idle bursts, except in the last phase.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_rle_sprite_run_scaler;

  localparam int FrameW   = 64;
  localparam int FrameH   = 64;
  localparam int TotalPix = FrameW * FrameH;
  // The pipeline is 6 deep; transparent runs leave no trace in the result
  // stream, so the bench keeps waiting after the last rectangle before a write.
  localparam int DrainCycles = 16;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          cfg_we = 1'b0;
  logic [1:0]                    cfg_idx = rsrs_pkg::CFG_ORIGIN_X;
  logic [rsrs_pkg::CfgDataW-1:0] cfg_wdata = '0;
  logic                          in_valid = 1'b0;
  logic                          in_stall_o;
  rsrs_pkg::in_t                 in_data = '0;
  logic                          out_valid_o;
  logic                          out_stall = 1'b0;
  rsrs_pkg::out_t                out_data_o;

  rle_sprite_run_scaler #(
    .FRAME_W(FrameW),
    .FRAME_H(FrameH)
  ) DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall),
    .out_data_o (out_data_o)
  );

  // Predictor state: the registers as last written and the sprite position.
  logic signed [10:0] cur_origin_x = '0;
  logic signed [10:0] cur_origin_y = '0;
  logic [9:0]         cur_draw_size = rsrs_pkg::DRAW_SIZE_RST;
  int                 sprite_pos = 0;

  rsrs_pkg::out_t pending_rects[$];
  int   fails = 0;
  int   run_count = 0;
  int   framed_runs = 0;
  int   rect_count = 0;
  int   setting_count = 0;
  // Random idle bursts on both channels; cleared for the final phase.
  bit   idle_on = 1'b1;

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic int clip(input int v, input int lo, input int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // Works out the rectangle for one accepted run and advances the position.
  // in_frame tells whether the run started inside the sprite.
  function automatic void predict_rect(input rsrs_pkg::in_t run, output bit in_frame);
    int   row, col, len, ox, oy, ds;
    int   rx, ry, rw, rh, left, right, top, bottom;
    rsrs_pkg::out_t r;
    in_frame = 1'b0;
    if (run.frame_start) sprite_pos = 0;
    // Once the position sits at the frame end, runs are dropped untouched.
    if (sprite_pos >= TotalPix) return;
    in_frame = 1'b1;
    row = sprite_pos / FrameW;
    col = sprite_pos % FrameW;
    len = run.run_length;
    sprite_pos = sprite_pos + len;
    if (sprite_pos > TotalPix) sprite_pos = TotalPix;
    // Transparent runs still move the position but draw nothing.
    if (run.color_code == '0) return;
    ox = cur_origin_x;
    oy = cur_origin_y;
    ds = cur_draw_size;
    if (ds == FrameW) begin
      // Native size: a one-pixel-high strip, not split at a row end.
      rx = ox + col;
      ry = oy + row;
      rw = len;
      rh = 1;
    end else begin
      left   = col * ds / FrameW;
      right  = (col + len) * ds / FrameW;
      top    = row * ds / FrameH;
      bottom = (row + 1) * ds / FrameH;
      rx = ox + left;
      ry = oy + top;
      rw = right - left;
      rh = bottom - top;
      if (rw < 1) rw = 1;
      if (rh < 1) rh = 1;
    end
    r.rect_x     = 12'(clip(rx, rsrs_pkg::RectPosMin, rsrs_pkg::RectPosMax));
    r.rect_y     = 12'(clip(ry, rsrs_pkg::RectPosMin, rsrs_pkg::RectPosMax));
    r.rect_w     = 13'(clip(rw, 0, rsrs_pkg::RectWMax));
    r.rect_h     = 10'(clip(rh, 0, rsrs_pkg::RectHMax));
    r.fill_index = run.color_code;
    pending_rects.push_back(r);
  endfunction

  // Sends one run and waits for its transfer. Valid is left high so that a
  // following call can present the next run without a bubble.
  task automatic push_run(input rsrs_pkg::in_t run, output bit in_frame);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= run;
    do @(posedge clk); while (in_stall_o);
    predict_rect(run, in_frame);
    run_count++;
    if (in_frame) framed_runs++;
  endtask

  task automatic send(input logic [7:0] len, input logic [7:0] color, input bit fs);
    rsrs_pkg::in_t run;
    bit            in_frame;
    run.run_length  = len;
    run.color_code  = color;
    run.frame_start = fs;
    push_run(run, in_frame);
  endtask

  // Stops the input and waits for every queued rectangle to come out.
  task automatic drain_pipeline();
    in_valid <= 1'b0;
    while (pending_rects.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx,
                           input logic [rsrs_pkg::CfgDataW-1:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      rsrs_pkg::CFG_ORIGIN_X:  cur_origin_x = data;
      rsrs_pkg::CFG_ORIGIN_Y:  cur_origin_y = data;
      rsrs_pkg::CFG_DRAW_SIZE: cur_draw_size = data[9:0];
      default: ;
    endcase
  endtask

  // Writes all three registers once the pipeline is empty. The spare top bit
  // of a draw size write is random; the block must ignore it.
  task automatic set_config(input int ox, input int oy, input int ds);
    drain_pipeline();
    write_reg(rsrs_pkg::CFG_ORIGIN_X, 11'(ox));
    write_reg(rsrs_pkg::CFG_ORIGIN_Y, 11'(oy));
    write_reg(rsrs_pkg::CFG_DRAW_SIZE, {1'($urandom_range(0, 1)), 10'(ds)});
    cfg_we <= 1'b0;
    setting_count++;
  endtask

  function automatic int rand_origin();
    return int'($urandom_range(0, 2047)) - 1024;
  endfunction

  function automatic int pick_draw_size();
    case ($urandom_range(0, 6))
      0:       return 0;
      1:       return 1;
      2:       return FrameW - 1;
      3:       return FrameW;
      4:       return FrameW + 1;
      5:       return 1023;
      default: return $urandom_range(1, 1023);
    endcase
  endfunction

  // Reset settings: native strips, zero-length strip, a run crossing a row
  // end, a transparent run and a restart.
  task automatic test_native_strips();
    send(8'd0, 8'd1, 1'b1);
    send(8'd255, 8'd255, 1'b0);
    send(8'd64, 8'd0, 1'b0);
    send(8'd1, 8'd128, 1'b0);
    send(8'd170, 8'd85, 1'b1);
  endtask

  // Scaled path at the largest size, at zero, at one and just off native.
  task automatic test_scaled_extremes();
    set_config(1023, -1024, 1023);
    send(8'd60, 8'd2, 1'b1);
    send(8'd200, 8'd4, 1'b0);
    send(8'd0, 8'd3, 1'b0);
    set_config(-1, 1, 0);
    send(8'd5, 8'd9, 1'b1);
    set_config(0, 0, 1);
    send(8'd255, 8'd170, 1'b1);
    set_config(-1024, 1023, FrameW + 1);
    send(8'd77, 8'd127, 1'b1);
  endtask

  // Fills the whole frame, overshoots its end, and then restarts the frame.
  // The run after the overshoot must give nothing.
  task automatic test_frame_end();
    set_config(-1024, -1024, FrameW);
    send(8'd255, 8'd11, 1'b1);
    repeat (15) send(8'd255, 8'($urandom_range(0, 255)), 1'b0);
    send(8'd20, 8'd5, 1'b0);
    send(8'd1, 8'd6, 1'b0);
    send(8'd3, 8'd7, 1'b1);
  endtask

  // Whole sprite frames with random runs. A few frames are cut short by an
  // early frame start, and some run a few transfers past the frame end.
  task automatic test_random_frames(input int n_runs, input int ox, input int oy,
                                    input int ds);
    int            used, filled, tail, pick, len;
    bit            start_next, in_frame;
    rsrs_pkg::in_t run;
    set_config(ox, oy, ds);
    used = 0;
    filled = 0;
    tail = 0;
    start_next = 1'b1;
    while (used < n_runs) begin
      if (start_next) tail = $urandom_range(0, 3);
      run.frame_start = start_next || ($urandom_range(0, 49) == 0);
      if (run.frame_start) filled = 0;
      pick = $urandom_range(0, 9);
      if (pick < 5) len = $urandom_range(0, 15);
      else if (pick < 8) len = $urandom_range(0, 63);
      else len = $urandom_range(0, 255);
      run.run_length = 8'(len);
      run.color_code = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
      push_run(run, in_frame);
      if (in_frame) used++;
      filled += len;
      start_next = 1'b0;
      if (filled >= TotalPix) begin
        if (tail == 0) start_next = 1'b1;
        else tail--;
      end
    end
  endtask

  // Output side: checks each output transfer against the oldest prediction,
  // and drives the output stall in random bursts.
  initial begin : rect_checker
    int             burst;
    rsrs_pkg::out_t want;
    burst = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid_o && !out_stall) begin
        rect_count++;
        if (pending_rects.size() == 0) begin
          $error("rectangle with no run pending: x %0d y %0d w %0d h %0d fill %0d",
                 out_data_o.rect_x, out_data_o.rect_y, out_data_o.rect_w,
                 out_data_o.rect_h, out_data_o.fill_index);
          fails++;
        end else begin
          want = pending_rects.pop_front();
          if (out_data_o.rect_x !== want.rect_x) begin
            $error("rect_x: expected %0d, got %0d", want.rect_x, out_data_o.rect_x);
            fails++;
          end
          if (out_data_o.rect_y !== want.rect_y) begin
            $error("rect_y: expected %0d, got %0d", want.rect_y, out_data_o.rect_y);
            fails++;
          end
          if (out_data_o.rect_w !== want.rect_w) begin
            $error("rect_w: expected %0d, got %0d", want.rect_w, out_data_o.rect_w);
            fails++;
          end
          if (out_data_o.rect_h !== want.rect_h) begin
            $error("rect_h: expected %0d, got %0d", want.rect_h, out_data_o.rect_h);
            fails++;
          end
          if (out_data_o.fill_index !== want.fill_index) begin
            $error("fill_index: expected %0d, got %0d", want.fill_index,
                   out_data_o.fill_index);
            fails++;
          end
        end
      end
      if (burst > 0) begin
        burst--;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 18);
      end
      out_stall <= (burst > 0);
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_native_strips();
    test_scaled_extremes();
    test_frame_end();
    test_random_frames(250, 0, 0, FrameW);
    test_random_frames(250, rand_origin(), rand_origin(), FrameW);
    test_random_frames(250, rand_origin(), rand_origin(), $urandom_range(1, 16));
    test_random_frames(250, rand_origin(), rand_origin(), pick_draw_size());
    // Last phase runs at full rate on both sides.
    idle_on = 1'b0;
    test_random_frames(250, rand_origin(), rand_origin(), pick_draw_size());
    drain_pipeline();

    $display("Sent %0d runs (%0d inside a frame) under %0d register settings;",
             run_count, framed_runs, setting_count);
    $display("checked %0d rectangles from native and scaled frames.", rect_count);
    if (fails == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/rsrs_pkg.sv
hw/rtl/rsrs_pos.sv
hw/rtl/rsrs_cdiv.sv
hw/rtl/rsrs_geom.sv
hw/rtl/rle_sprite_run_scaler.sv
tb/tb_rle_sprite_run_scaler.sv
